@@ sv/apr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apr_pkg: shared types and constants of the accelerating phase rotator
// Field widths, register codes, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int unsigned DUR_W       = 16;
    localparam int unsigned ACC_W       = 32;
    localparam int unsigned RAD_W       = 10;
    localparam int unsigned ORG_W       = 12;
    localparam int unsigned END_W       = 18;
    localparam int unsigned PHASE_W     = 32;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam int unsigned CORDIC_STEPS_DEF = 16;
    localparam int unsigned ATAN_LEN    = 24;
    localparam int unsigned ATAN_IDX_W  = 5;

    // Gain-compensated start value per pixel of radius (1/16 pixel, 20 fraction bits).
    localparam logic [23:0] CORDIC_GAIN = 24'd10188014;
    localparam int unsigned FRAC_BITS   = 20;

    localparam logic signed [ACC_W-1:0]   ACC_RESET    = 32'sd5340353;
    localparam logic [RAD_W-1:0]          RAD_RESET    = 10'd40;
    localparam logic [ORG_W-1:0]          ORGX_RESET   = 12'd160;
    localparam logic [ORG_W-1:0]          ORGY_RESET   = 12'd128;
    localparam logic [PHASE_W-1:0]        PHASE_RESET  = 32'd683565276;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 8'd3;

    typedef logic [DUR_W-1:0]            t_dur;
    typedef logic signed [END_W-1:0]     t_end;
    typedef logic [PHASE_W-1:0]          t_phase;
    typedef logic [CFG_IDX_W-1:0]        t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]       t_cfg_data;

    // Arctangent of 2^-i in Q0.32 turns.
    function automatic logic [31:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/apr_tick_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apr_tick_if: tick request channel
// Carries the duration of one time tick with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface apr_tick_if;
    logic          valid;
    logic          ready;
    apr_pkg::t_dur tick_duration;

    modport source (output valid, output tick_duration, input ready);
    modport sink   (input valid, input tick_duration, output ready);
endinterface

@@ sv/apr_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apr_result_if: endpoint result channel
// Carries the endpoint coordinates and the updated phase.
// ----------------------------------------------------------------------------
interface apr_result_if;
    logic            valid;
    logic            ready;
    apr_pkg::t_end   end_x;
    apr_pkg::t_end   end_y;
    apr_pkg::t_phase phase_out;

    modport source (output valid, output end_x, output end_y, output phase_out, input ready);
    modport sink   (input valid, input end_x, input end_y, input phase_out, output ready);
endinterface

@@ sv/apr_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apr_cfg_if: configuration write channel
// Carries a register index and the data to write.
// ----------------------------------------------------------------------------
interface apr_cfg_if;
    logic               valid;
    logic               ready;
    apr_pkg::t_cfg_idx  index;
    apr_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/accelerating_phase_rotator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accelerating_phase_rotator: accelerating arm with CORDIC endpoint
// Integrates acceleration into speed and speed into phase, then rotates a
// configured radius around a configured origin.
// ----------------------------------------------------------------------------
// Usage:
// Each request on i_tick carries one tick duration (Q0.16 s). The block adds
// acceleration*duration to the saturating angular speed, adds speed*duration
// to the wrapping Q0.32 phase, and returns one result on o_result: the arm
// endpoint in 1/16 pixel and the new phase.
// i_cfg writes acceleration, radius, origin_x and origin_y (indexes 0 to 3);
// other indexes are ignored. It is always ready; write it only when idle.
// A tick passes the single shared 32x17 multiplier, used twice, and then the
// one-step-per-cycle CORDIC rotator before its result is registered. i_tick
// is ready only while the sequencer is idle, so a new tick is not taken until
// the previous result has moved into the output register.
// The result sits in an output register; the next tick is taken while it
// waits, and the sequencer holds its last state until the receiver drains it.
// Synchronous reset restores the register defaults, zero speed and a phase
// of one radian.
// ----------------------------------------------------------------------------
module accelerating_phase_rotator #(
    parameter int unsigned CORDIC_STEPS = apr_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    apr_tick_if.sink      i_tick,
    apr_cfg_if.sink       i_cfg,
    apr_result_if.source  o_result
);
    import apr_pkg::*;

    localparam int unsigned CNT_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int unsigned XW     = 37;
    localparam int unsigned ZW     = 34;
    localparam int unsigned PROD_W = 48;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_AMUL = 7'b0000010,
        S_SPD  = 7'b0000100,
        S_VMUL = 7'b0001000,
        S_PHS  = 7'b0010000,
        S_ROT  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                     r_state, n_state;
    logic signed [ACC_W-1:0]    r_accel;
    logic [RAD_W-1:0]           r_radius;
    logic [ORG_W-1:0]           r_org_x, r_org_y;
    logic signed [ACC_W-1:0]    r_speed;
    logic [PHASE_W-1:0]         r_phase;
    logic [DUR_W-1:0]           r_dur;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [XW-1:0]       r_x, r_y;
    logic signed [ZW-1:0]       r_z;
    logic [1:0]                 r_quad;
    logic [CNT_W-1:0]           r_step;
    logic                       r_out_valid;
    t_end                       r_end_x, r_end_y;
    t_phase                     r_phase_out;

    // Shared multiplier: acceleration or speed times the tick duration.
    logic signed [ACC_W-1:0]    mul_a;
    logic signed [PROD_W:0]     mul_full;
    logic signed [ACC_W-1:0]    dv;
    logic signed [ACC_W:0]      v_sum;
    logic signed [ACC_W-1:0]    v_sat;
    logic [PHASE_W-1:0]         phase_new;
    logic [1:0]                 quad;
    logic [PHASE_W-1:0]         z_start;
    logic [33:0]                x_start;
    logic signed [XW-1:0]       xs, ys;
    logic signed [ZW-1:0]       atan_z;
    logic signed [XW-1:0]       fx, fy;
    logic signed [XW-1:0]       rx, ry;
    logic signed [XW-1:0]       ex, ey;
    logic                       out_free;
    logic                       last_step;

    assign mul_a    = (r_state == S_AMUL) ? r_accel : r_speed;
    assign mul_full = mul_a * $signed({1'b0, r_dur});

    assign dv    = r_prod[PROD_W-1:16];
    assign v_sum = {r_speed[ACC_W-1], r_speed} + {dv[ACC_W-1], dv};
    always_comb begin
        if (v_sum[ACC_W] != v_sum[ACC_W-1]) begin
            v_sat = v_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            v_sat = v_sum[ACC_W-1:0];
        end
    end

    assign phase_new = r_phase + r_prod[39:8];
    // Quadrant of the new phase, with the residual centered on it.
    assign quad      = 2'(phase_new + 32'h2000_0000 >> 30);
    assign z_start   = phase_new - {quad, 30'b0};
    assign x_start   = r_radius * CORDIC_GAIN;

    assign xs        = r_x >>> r_step;
    assign ys        = r_y >>> r_step;
    assign atan_z    = $signed({2'b00, atan_turns(ATAN_IDX_W'(r_step))});
    assign last_step = (r_step == CNT_W'(CORDIC_STEPS - 1));

    always_comb begin
        unique case (r_quad)
            2'd1:    begin fx = -r_y; fy = r_x;  end
            2'd2:    begin fx = -r_x; fy = -r_y; end
            2'd3:    begin fx = r_y;  fy = -r_x; end
            default: begin fx = r_x;  fy = r_y;  end
        endcase
    end

    assign rx = (fx + $signed(XW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign ry = (fy + $signed(XW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign ex = $signed(XW'({r_org_x, 4'b0000})) + rx;
    assign ey = $signed(XW'({r_org_y, 4'b0000})) + ry;

    assign out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_tick.valid) n_state = S_AMUL;
            S_AMUL: n_state = S_SPD;
            S_SPD:  n_state = S_VMUL;
            S_VMUL: n_state = S_PHS;
            S_PHS:  n_state = S_ROT;
            S_ROT:  if (last_step) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_accel     <= ACC_RESET;
            r_radius    <= RAD_RESET;
            r_org_x     <= ORGX_RESET;
            r_org_y     <= ORGY_RESET;
            r_speed     <= '0;
            r_phase     <= PHASE_RESET;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_ACCEL:    r_accel  <= $signed(i_cfg.data[ACC_W-1:0]);
                    REG_RADIUS:   r_radius <= i_cfg.data[RAD_W-1:0];
                    REG_ORIGIN_X: r_org_x  <= i_cfg.data[ORG_W-1:0];
                    REG_ORIGIN_Y: r_org_y  <= i_cfg.data[ORG_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == S_SPD) begin
                r_speed <= v_sat;
            end
            if (r_state == S_PHS) begin
                r_phase <= phase_new;
                r_step  <= '0;
            end
            if (r_state == S_ROT && !last_step) begin
                r_step <= r_step + CNT_W'(1);
            end

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_tick.valid) begin
            r_dur <= i_tick.tick_duration;
        end
        if (r_state == S_AMUL || r_state == S_VMUL) begin
            r_prod <= mul_full[PROD_W-1:0];
        end
        if (r_state == S_PHS) begin
            r_quad <= quad;
            r_z    <= ZW'($signed(z_start));
            r_x    <= $signed(XW'(x_start));
            r_y    <= '0;
        end
        if (r_state == S_ROT) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_z;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_z;
            end
        end
        if (r_state == S_OUT && out_free) begin
            r_end_x     <= ex[END_W-1:0];
            r_end_y     <= ey[END_W-1:0];
            r_phase_out <= r_phase;
        end
    end

    assign i_tick.ready       = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_result.valid     = r_out_valid;
    assign o_result.end_x     = r_end_x;
    assign o_result.end_y     = r_end_y;
    assign o_result.phase_out = r_phase_out;

endmodule
